>>> hw/rtl/iec104_pkg.sv
// ----------------------------------------------------------------------------
// IEC 104 APCI parser package
// Shared constants, frame state and result types, U-frame function lookup.
// ----------------------------------------------------------------------------
package iec104_pkg;

  localparam int PosW = 9;
  localparam logic [PosW-1:0] POS_MAX = '1;

  localparam logic [7:0] START_BYTE = 8'h68;

  // configuration register indexes
  localparam logic CFG_COT_SIZE = 1'b0;
  localparam logic CFG_CA_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_I     = 2'd0,
    KIND_S     = 2'd1,
    KIND_U     = 2'd2,
    KIND_SHORT = 2'd3
  } frame_kind_t;

  // error mask bit positions
  localparam int ERR_TOO_SHORT    = 0;
  localparam int ERR_BAD_START    = 1;
  localparam int ERR_LEN_MISMATCH = 2;
  localparam int ERR_NO_APCI      = 3;
  localparam int ERR_NO_ASDU      = 4;
  localparam int ERR_SHORT_HDR    = 5;
  localparam int ERR_PRIV_TYPE    = 6;
  localparam int ERR_ZERO_OBJ     = 7;
  localparam int ERR_S_CF2        = 8;
  localparam int ERR_S_LEN        = 9;
  localparam int ERR_U_CF         = 10;
  localparam int ERR_U_LEN        = 11;

  // U-frame function codes
  localparam logic [2:0] UF_UNKNOWN     = 3'd0;
  localparam logic [2:0] UF_STARTDT_ACT = 3'd1;
  localparam logic [2:0] UF_STARTDT_CON = 3'd2;
  localparam logic [2:0] UF_STOPDT_ACT  = 3'd3;
  localparam logic [2:0] UF_STOPDT_CON  = 3'd4;
  localparam logic [2:0] UF_TESTFR_ACT  = 3'd5;
  localparam logic [2:0] UF_TESTFR_CON  = 3'd6;

  typedef struct packed {
    logic        start_error;
    logic [7:0]  decl_len;
    logic [7:0]  cf1;
    logic [7:0]  cf2;
    logic [7:0]  cf3;
    logic [7:0]  cf4;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_qual;
    logic [7:0]  hdr_cause;
    logic [7:0]  hdr_orig;
    logic [15:0] hdr_addr;
  } frame_state_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [14:0] send_seq;
    logic [14:0] recv_seq;
    logic [2:0]  u_function;
    logic [7:0]  type_id;
    logic [6:0]  object_count;
    logic        sequence_flag;
    logic [5:0]  cause;
    logic [1:0]  cot_flags;
    logic [7:0]  originator;
    logic [15:0] common_address;
    logic [11:0] error_mask;
  } result_t;

  function automatic logic [2:0] u_code(input logic [7:0] cf1);
    logic [2:0] code;
    unique case (cf1)
      8'h07:   code = UF_STARTDT_ACT;
      8'h0B:   code = UF_STARTDT_CON;
      8'h13:   code = UF_STOPDT_ACT;
      8'h23:   code = UF_STOPDT_CON;
      8'h43:   code = UF_TESTFR_ACT;
      8'h83:   code = UF_TESTFR_CON;
      default: code = UF_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/iec104_decode.sv
// ----------------------------------------------------------------------------
// IEC 104 frame decode
// Classifies a finished frame and builds its result from the frame state.
// ----------------------------------------------------------------------------
module iec104_decode (
  input  logic [8:0]                  last_pos,
  input  iec104_pkg::frame_state_t    frame,
  input  logic                        cot2,
  input  logic                        ca2,
  output iec104_pkg::result_t         result
);
  import iec104_pkg::*;

  logic [8:0] hdr_end;
  logic [8:0] len_after;

  // header complete when at least 9 bytes, plus one per two-byte cot or ca size, precede the last one
  assign hdr_end   = 9'd9 + {8'd0, cot2} + {8'd0, ca2};
  assign len_after = last_pos - 9'd1;

  always_comb begin
    result            = '0;
    result.frame_kind = KIND_SHORT;
    if (last_pos == '0) begin
      result.error_mask[ERR_TOO_SHORT] = 1'b1;
    end else begin
      result.error_mask[ERR_BAD_START]    = frame.start_error;
      result.error_mask[ERR_LEN_MISMATCH] = ({1'b0, frame.decl_len} != len_after);
      if (last_pos < 9'd5) begin
        result.error_mask[ERR_NO_APCI] = 1'b1;
      end else if (!frame.cf1[0]) begin
        result.frame_kind = KIND_I;
        result.send_seq   = {frame.cf2[7:0], frame.cf1[7:1]};
        result.recv_seq   = {frame.cf4[7:0], frame.cf3[7:1]};
        if (last_pos == 9'd5) begin
          result.error_mask[ERR_NO_ASDU] = 1'b1;
        end else if (last_pos < hdr_end) begin
          result.error_mask[ERR_SHORT_HDR] = 1'b1;
        end else begin
          result.type_id        = frame.hdr_type;
          result.object_count   = frame.hdr_qual[6:0];
          result.sequence_flag  = frame.hdr_qual[7];
          result.cause          = frame.hdr_cause[5:0];
          result.cot_flags      = {frame.hdr_cause[7], frame.hdr_cause[6]};
          result.originator     = cot2 ? frame.hdr_orig : 8'd0;
          result.common_address = ca2 ? frame.hdr_addr : {8'd0, frame.hdr_addr[7:0]};
          result.error_mask[ERR_PRIV_TYPE] = frame.hdr_type[7];
          result.error_mask[ERR_ZERO_OBJ]  = (frame.hdr_qual[6:0] == 7'd0);
        end
      end else if (!frame.cf1[1]) begin
        result.frame_kind = KIND_S;
        result.recv_seq   = {frame.cf4[7:0], frame.cf3[7:1]};
        result.error_mask[ERR_S_CF2] = (frame.cf2 != 8'd0);
        result.error_mask[ERR_S_LEN] = (last_pos != 9'd5);
      end else begin
        result.frame_kind = KIND_U;
        result.u_function = u_code(frame.cf1);
        result.error_mask[ERR_U_CF]  = ((frame.cf2 | frame.cf3 | frame.cf4) != 8'd0);
        result.error_mask[ERR_U_LEN] = (last_pos != 9'd5);
      end
    end
  end

endmodule

>>> hw/rtl/iec104_apci_frame_parser_core.sv
// ----------------------------------------------------------------------------
// IEC 104 APCI frame parser core
// Parses an APDU byte stream and gives one decoded result per frame.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  data_byte, last_byte
//   out      output     out_valid/out_stall frame_kind .. error_mask
//   cfg      input      cfg_write          cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; the result of a frame appears the
// cycle after its last byte is taken, set by the single result register
// behind the decode logic. Reset clears the byte position, frame state and
// output valid, and sets both size registers to 2.
// in_stall is high only while a result waits and out_stall holds it.
// ----------------------------------------------------------------------------
module iec104_apci_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_kind,
  output logic [14:0] send_seq,
  output logic [14:0] recv_seq,
  output logic [2:0]  u_function,
  output logic [7:0]  type_id,
  output logic [6:0]  object_count,
  output logic        sequence_flag,
  output logic [5:0]  cause,
  output logic [1:0]  cot_flags,
  output logic [7:0]  originator,
  output logic [15:0] common_address,
  output logic [11:0] error_mask,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);
  import iec104_pkg::*;

  logic [1:0]     cot_size;
  logic [1:0]     ca_size;
  logic [8:0]     byte_position;
  logic [8:0]     byte_position_next;
  frame_state_t   frame;
  frame_state_t   frame_next;
  result_t        result_next;
  result_t        result;
  logic           in_accept;
  logic           cot2;
  logic           ca2;
  logic [8:0]     ca_off;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // values 0 and 1 act as one byte, 2 and 3 as two
  assign cot2   = cot_size[1];
  assign ca2    = ca_size[1];
  // common address starts right after the cause bytes
  assign ca_off = 9'd9 + {8'd0, cot2};

  always_ff @(posedge clk) begin
    if (rst) begin
      cot_size <= 2'd2;
      ca_size  <= 2'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COT_SIZE: cot_size <= cfg_data;
        CFG_CA_SIZE:  ca_size  <= cfg_data;
        default:      cot_size <= cot_size;
      endcase
    end
  end

  always_comb begin
    frame_next = frame;
    if (byte_position == 9'd0) begin
      frame_next.start_error = (data_byte != START_BYTE);
      frame_next.decl_len    = 8'd0;
      frame_next.hdr_type    = 8'd0;
      frame_next.hdr_qual    = 8'd0;
      frame_next.hdr_cause   = 8'd0;
      frame_next.hdr_orig    = 8'd0;
      frame_next.hdr_addr    = 16'd0;
    end else if (byte_position == 9'd1) begin
      frame_next.decl_len = data_byte;
    end else if (byte_position == 9'd2) begin
      frame_next.cf1 = data_byte;
    end else if (byte_position == 9'd3) begin
      frame_next.cf2 = data_byte;
    end else if (byte_position == 9'd4) begin
      frame_next.cf3 = data_byte;
    end else if (byte_position == 9'd5) begin
      frame_next.cf4 = data_byte;
    end else if (byte_position == 9'd6) begin
      frame_next.hdr_type = data_byte;
    end else if (byte_position == 9'd7) begin
      frame_next.hdr_qual = data_byte;
    end else if (byte_position == 9'd8) begin
      frame_next.hdr_cause = data_byte;
    end else begin
      if (byte_position == 9'd9 && cot2) begin
        frame_next.hdr_orig = data_byte;
      end
      if (byte_position == ca_off) begin
        frame_next.hdr_addr[7:0] = data_byte;
      end else if (byte_position == ca_off + 9'd1 && ca2) begin
        frame_next.hdr_addr[15:8] = data_byte;
      end
    end
  end

  always_comb begin
    if (last_byte) begin
      byte_position_next = 9'd0;
    end else if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + 9'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  iec104_decode u_decode (
    .last_pos (byte_position),
    .frame    (frame_next),
    .cot2     (cot2),
    .ca2      (ca2),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 9'd0;
      frame         <= '0;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
      frame         <= frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // load the result with the last byte of a frame
  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      result <= result_next;
    end
  end

  assign frame_kind     = result.frame_kind;
  assign send_seq       = result.send_seq;
  assign recv_seq       = result.recv_seq;
  assign u_function     = result.u_function;
  assign type_id        = result.type_id;
  assign object_count   = result.object_count;
  assign sequence_flag  = result.sequence_flag;
  assign cause          = result.cause;
  assign cot_flags      = result.cot_flags;
  assign originator     = result.originator;
  assign common_address = result.common_address;
  assign error_mask     = result.error_mask;

`ifndef ASSERT_OFF
  a_rose_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept && last_byte))
    else $error("result shown without a finished frame");

  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_byte) |=> (byte_position == 9'd0))
    else $error("byte position not restarted after last byte");

  a_short_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind == KIND_SHORT) |->
      (send_seq == 15'd0 && recv_seq == 15'd0 && type_id == 8'd0 &&
       error_mask[11:4] == 8'd0))
    else $error("unclassified frame carries decoded fields");

  a_ns_only_i: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind != KIND_I) |-> (send_seq == 15'd0 && type_id == 8'd0))
    else $error("send sequence or header set outside an I frame");
`endif

endmodule

>>> sim/apci_frame_checker.sv
// ----------------------------------------------------------------------------
// APCI frame parser checker
// Watches the byte, result and register ports of the parser, decodes each
// frame on its own from the accepted bytes and compares every field of every
// accepted result against the oldest decoded frame still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module apci_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  frame_kind,
  input  logic [14:0] send_seq,
  input  logic [14:0] recv_seq,
  input  logic [2:0]  u_function,
  input  logic [7:0]  type_id,
  input  logic [6:0]  object_count,
  input  logic        sequence_flag,
  input  logic [5:0]  cause,
  input  logic [1:0]  cot_flags,
  input  logic [7:0]  originator,
  input  logic [15:0] common_address,
  input  logic [11:0] error_mask,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import iec104_pkg::*;

  // U-frame control bytes
  localparam logic [7:0] CF_STARTDT_ACT = 8'h07;
  localparam logic [7:0] CF_STARTDT_CON = 8'h0B;
  localparam logic [7:0] CF_STOPDT_ACT  = 8'h13;
  localparam logic [7:0] CF_STOPDT_CON  = 8'h23;
  localparam logic [7:0] CF_TESTFR_ACT  = 8'h43;
  localparam logic [7:0] CF_TESTFR_CON  = 8'h83;

  result_t     decoded_q[$];
  result_t     oldest;

  logic [1:0]  cot_reg;
  logic [1:0]  ca_reg;
  logic [8:0]  byte_pos;
  logic [7:0]  len_field;
  logic [7:0]  ctrl [4];
  logic [7:0]  type_byte;
  logic [7:0]  vsq_byte;
  logic [7:0]  cot_byte;
  logic [7:0]  orig_byte;
  logic [15:0] addr_word;
  logic        start_bad;

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    int      pos;
    int      total;
    int      cot_n;
    int      ca_n;
    int      ca_at;
    int      asdu_len;
    result_t r;
    pos   = byte_pos;
    cot_n = (cot_reg >= 2) ? 2 : 1;
    ca_n  = (ca_reg >= 2) ? 2 : 1;
    ca_at = 8 + cot_n;

    if (pos == 0) begin
      len_field = '0;
      type_byte = '0;
      vsq_byte  = '0;
      cot_byte  = '0;
      orig_byte = '0;
      addr_word = '0;
      start_bad = (b != START_BYTE);
    end else if (pos == 1) begin
      len_field = b;
    end else if (pos <= 5) begin
      ctrl[pos-2] = b;
    end else if (pos == 6) begin
      type_byte = b;
    end else if (pos == 7) begin
      vsq_byte = b;
    end else if (pos == 8) begin
      cot_byte = b;
    end else begin
      if (pos == 9 && cot_n == 2) orig_byte = b;
      if (pos == ca_at) addr_word[7:0] = b;
      else if (pos == ca_at + 1 && ca_n == 2) addr_word[15:8] = b;
    end
    // saturate on very long frames
    if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;

    if (is_last) begin
      total    = pos + 1;
      byte_pos = '0;
      r = '0;
      r.frame_kind = KIND_SHORT;
      if (total < 2) begin
        r.error_mask[ERR_TOO_SHORT] = 1'b1;
      end else begin
        r.error_mask[ERR_BAD_START]    = start_bad;
        r.error_mask[ERR_LEN_MISMATCH] = (int'(len_field) != total - 2);
        if (total < 6) begin
          r.error_mask[ERR_NO_APCI] = 1'b1;
        end else if (!ctrl[0][0]) begin
          r.frame_kind = KIND_I;
          r.send_seq   = {ctrl[1], ctrl[0][7:1]};
          r.recv_seq   = {ctrl[3], ctrl[2][7:1]};
          asdu_len     = total - 6;
          if (asdu_len < 1) begin
            r.error_mask[ERR_NO_ASDU] = 1'b1;
          end else if (asdu_len < 2 + cot_n + ca_n) begin
            r.error_mask[ERR_SHORT_HDR] = 1'b1;
          end else begin
            r.type_id        = type_byte;
            r.object_count   = vsq_byte[6:0];
            r.sequence_flag  = vsq_byte[7];
            r.cause          = cot_byte[5:0];
            r.cot_flags      = cot_byte[7:6];
            r.originator     = (cot_n == 2) ? orig_byte : 8'h00;
            r.common_address = (ca_n == 2) ? addr_word : {8'h00, addr_word[7:0]};
            r.error_mask[ERR_PRIV_TYPE] = type_byte[7];
            r.error_mask[ERR_ZERO_OBJ]  = (vsq_byte[6:0] == '0);
          end
        end else if (!ctrl[0][1]) begin
          r.frame_kind = KIND_S;
          r.recv_seq   = {ctrl[3], ctrl[2][7:1]};
          r.error_mask[ERR_S_CF2] = (ctrl[1] != '0);
          r.error_mask[ERR_S_LEN] = (total != 6);
        end else begin
          r.frame_kind = KIND_U;
          case (ctrl[0])
            CF_STARTDT_ACT: r.u_function = UF_STARTDT_ACT;
            CF_STARTDT_CON: r.u_function = UF_STARTDT_CON;
            CF_STOPDT_ACT:  r.u_function = UF_STOPDT_ACT;
            CF_STOPDT_CON:  r.u_function = UF_STOPDT_CON;
            CF_TESTFR_ACT:  r.u_function = UF_TESTFR_ACT;
            CF_TESTFR_CON:  r.u_function = UF_TESTFR_CON;
            default:        r.u_function = UF_UNKNOWN;
          endcase
          r.error_mask[ERR_U_CF]  = ((ctrl[1] | ctrl[2] | ctrl[3]) != '0);
          r.error_mask[ERR_U_LEN] = (total != 6);
        end
      end
      decoded_q = {decoded_q, r};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      decoded_q.delete();
      fail_count = 0;
      cot_reg    = 2'd2;
      ca_reg     = 2'd2;
      byte_pos   = '0;
      len_field  = '0;
      type_byte  = '0;
      vsq_byte   = '0;
      cot_byte   = '0;
      orig_byte  = '0;
      addr_word  = '0;
      start_bad  = 1'b0;
      for (int i = 0; i < 4; i++) ctrl[i] = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_COT_SIZE: cot_reg = cfg_data;
          CFG_CA_SIZE:  ca_reg  = cfg_data;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result item with no frame waiting for it");
          fail_count++;
        end else begin
          oldest = decoded_q.pop_front();
          check_field("frame_kind", oldest.frame_kind, frame_kind);
          check_field("send_seq", oldest.send_seq, send_seq);
          check_field("recv_seq", oldest.recv_seq, recv_seq);
          check_field("u_function", oldest.u_function, u_function);
          check_field("type_id", oldest.type_id, type_id);
          check_field("object_count", oldest.object_count, object_count);
          check_field("sequence_flag", oldest.sequence_flag, sequence_flag);
          check_field("cause", oldest.cause, cause);
          check_field("cot_flags", oldest.cot_flags, cot_flags);
          check_field("originator", oldest.originator, originator);
          check_field("common_address", oldest.common_address, common_address);
          check_field("error_mask", oldest.error_mask, error_mask);
        end
      end
      if (in_valid && !in_stall) decode_byte(data_byte, last_byte);
    end
    pending = decoded_q.size();
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// APCI frame parser testbench
// Feeds short directed frames, then random I, S and U frames mixed with
// broken and noise frames under several size settings, with random idling
// on both ports, a long result hold-off and a very long frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import iec104_pkg::*;

  localparam int NUM_PHASES      = 6;
  localparam int BYTES_PER_PHASE = 185;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 6;
  localparam int LONG_FRAME      = 520;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int QUIET_PHASE     = 4;
  localparam int HOLD_PHASE      = 1;
  localparam int LONG_PHASE      = 2;

  // size settings per phase, out-of-range values included
  localparam logic [2*NUM_PHASES-1:0] COT_PLAN = {2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1};
  localparam logic [2*NUM_PHASES-1:0] CA_PLAN  = {2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd1};

  // low control bits by frame format
  localparam logic       FMT_I = 1'b0;
  localparam logic [1:0] FMT_S = 2'b01;
  localparam logic [1:0] FMT_U = 2'b11;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  frame_kind;
  logic [14:0] send_seq;
  logic [14:0] recv_seq;
  logic [2:0]  u_function;
  logic [7:0]  type_id;
  logic [6:0]  object_count;
  logic        sequence_flag;
  logic [5:0]  cause;
  logic [1:0]  cot_flags;
  logic [7:0]  originator;
  logic [15:0] common_address;
  logic [11:0] error_mask;
  logic        cfg_write;
  logic        cfg_index;
  logic [1:0]  cfg_data;

  int          fail_count;
  int          pending;
  int          cycle_count;
  int          bytes_sent;
  int          cot_eff;
  int          ca_eff;
  bit          idle_on;
  int          hold_requests;
  int          holds_done;
  int          hold_left;
  logic [7:0]  frame[$];

  iec104_apci_frame_parser_core dut (.*);

  apci_frame_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 37);
    end
  end

  function automatic logic [7:0] u_ctrl_byte(input int fn);
    return {6'(1 << fn), FMT_U};
  endfunction

  task automatic add_byte(input logic [7:0] value);
    frame = {frame, value};
  endtask

  // valid is left high on return; callers drop it before waiting
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while (idle_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= value;
    last_byte <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    bytes_sent += frame.size();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic make_frame();
    int          sel;
    int          hdr_len;
    bit          fix_len;
    logic [14:0] ns;
    logic [14:0] nr;
    frame.delete();
    fix_len = 1'b1;
    sel     = $urandom_range(99);
    ns      = 15'($urandom);
    nr      = 15'($urandom);
    hdr_len = 2 + cot_eff + ca_eff;
    if (sel < 80) begin
      add_byte(START_BYTE);
      add_byte(8'h00);
    end
    if (sel < 50) begin
      add_byte({ns[6:0], FMT_I});
      add_byte(ns[14:7]);
      add_byte({nr[6:0], 1'($urandom)});
      add_byte(nr[14:7]);
      case ($urandom_range(9))
        0: ;
        1: repeat ($urandom_range(1, hdr_len - 1)) add_byte(8'($urandom));
        default: begin
          add_byte(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(127)));
          add_byte(($urandom_range(7) == 0) ? {1'($urandom), 7'd0} : 8'($urandom));
          repeat (hdr_len - 2 + $urandom_range(12)) add_byte(8'($urandom));
        end
      endcase
    end else if (sel < 65) begin
      add_byte({6'($urandom), FMT_S});
      add_byte(($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
      add_byte(8'($urandom));
      add_byte(8'($urandom));
    end else if (sel < 80) begin
      add_byte(($urandom_range(3) == 0) ? {6'($urandom), FMT_U}
                                        : u_ctrl_byte($urandom_range(5)));
      repeat (3) add_byte(($urandom_range(7) == 0) ? 8'($urandom) : 8'h00);
    end else begin
      // noise: random length and content
      fix_len = 1'b0;
      repeat ($urandom_range(1, 14)) add_byte(8'($urandom));
      if ($urandom_range(1) == 0) frame[0] = START_BYTE;
    end
    if (sel >= 50 && sel < 80 && $urandom_range(9) == 0)
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    if (fix_len) begin
      frame[1] = 8'(frame.size() - 2);
      if ($urandom_range(19) == 0) frame[1] = 8'($urandom);
      if ($urandom_range(19) == 0) frame[0] = 8'($urandom);
    end
  endtask

  initial begin
    int phase_start;
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_byte     = '0;
    last_byte     = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_COT_SIZE;
    cfg_data      = '0;
    idle_on       = 1'b1;
    hold_requests = 0;
    bytes_sent    = 0;
    cot_eff       = 2;
    ca_eff        = 2;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames at reset sizes
    frame = '{START_BYTE};
    send_frame();
    frame = '{8'h55, 8'h00};
    send_frame();
    frame = '{START_BYTE, 8'h03, 8'h00, 8'h00, 8'h00};
    send_frame();
    frame = '{START_BYTE, 8'h04, {6'd0, FMT_S}, 8'h00, 8'hFE, 8'hFF};
    send_frame();
    frame = '{START_BYTE, 8'h04, u_ctrl_byte(0), 8'h00, 8'h00, 8'h00};
    send_frame();
    frame = '{START_BYTE, 8'h0A, 8'hFE, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_COT_SIZE, COT_PLAN[2*ph +: 2]);
      write_reg(CFG_CA_SIZE, CA_PLAN[2*ph +: 2]);
      cot_eff = (COT_PLAN[2*ph +: 2] >= 2) ? 2 : 1;
      ca_eff  = (CA_PLAN[2*ph +: 2] >= 2) ? 2 : 1;
      idle_on = (ph != QUIET_PHASE);
      // hold results off while frames keep coming
      if (ph == HOLD_PHASE) hold_requests++;
      if (ph == LONG_PHASE) begin
        frame.delete();
        add_byte(START_BYTE);
        repeat (LONG_FRAME - 1) add_byte(8'($urandom));
        send_frame();
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        make_frame();
        send_frame();
      end
      settle();
    end

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/iec104_pkg.sv
hw/rtl/iec104_decode.sv
hw/rtl/iec104_apci_frame_parser_core.sv
sim/apci_frame_checker.sv
sim/testbench.sv
